@@ src/curved_capsule_point_projection_defines.svh @@
// Assertion macros for the bent-tube point projection block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef CURVED_CAPSULE_POINT_PROJECTION_DEFINES_SVH
`define CURVED_CAPSULE_POINT_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCPP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ccpp_pkg.sv @@
// Package of the bent-tube point projection block: beat types, pipeline
// context types, register indexes and the output saturation function.
// No dependencies.
`default_nettype none

package ccpp_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ARC_RADIUS  = 3'd0,
    CFG_TUBE_RADIUS = 3'd1,
    CFG_END_X       = 3'd2,
    CFG_END_Y       = 3'd3,
    CFG_CENTER_Y    = 3'd4
  } cfg_idx_e;

  localparam logic [30:0] ArcRadiusRst  = 31'd1310720;
  localparam logic [30:0] TubeRadiusRst = 31'd131072;
  localparam logic [30:0] EndXRst       = 31'd324277;
  localparam logic [30:0] EndYRst       = 31'd20327;
  localparam logic [31:0] CenterYRst    = 32'd1290393;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_beat_t;

  typedef struct packed {
    logic               is_inside;
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic               degenerate;
  } out_beat_t;

  // Context riding along the first square root.
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        neg_x;
    logic        neg_y;
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic        zero1;
  } ctx_a_t;

  // Context riding along the first divider.
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        neg_x;
    logic        neg_y;
    logic        zero1;
  } ctx_b_t;

  // Context riding along the second square root.
  typedef struct packed {
    logic [31:0] bx;
    logic [33:0] by;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic [31:0] mag_z;
    logic        is_inside;
    logic        zero1;
    logic        zero2;
  } ctx_c_t;

  // Context riding along the second divider.
  typedef struct packed {
    logic [31:0] bx;
    logic [33:0] by;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        is_inside;
    logic        zero1;
    logic        zero2;
  } ctx_d_t;

  function automatic logic [31:0] sat32(input logic [35:0] v);
    logic [31:0] r;
    if ($signed(v) > $signed(36'sh07FFFFFFF)) begin
      r = 32'h7FFFFFFF;
    end else if ($signed(v) < $signed(-36'sh080000000)) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/curved_capsule_point_projection.sv @@
// Bent-tube point projection top level; uses ccpp_pkg, ccpp_sqrt, ccpp_div.
// The pipeline is two 34-stage square roots, two 31-stage dividers (one
// quotient bit per stage) and ten stages of multiply, add and clamp logic.
// One point per cycle is sustained while the output is not stalled; a
// stalled output freezes the whole pipeline. Reset clears all valid bits
// and returns the configuration registers to their defaults.
`default_nettype none
`include "curved_capsule_point_projection_defines.svh"

module curved_capsule_point_projection #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ccpp_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ccpp_pkg::out_beat_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ccpp_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [ccpp_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  localparam int unsigned RootW = 34;
  localparam int unsigned RadW  = 2 * RootW;
  localparam int unsigned NumW  = 64;
  localparam int unsigned QuoW  = 31;

  // Configuration.
  logic [30:0] arc_radius_q, tube_radius_q, end_x_q, end_y_q;
  logic [31:0] center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_radius_q  <= ccpp_pkg::ArcRadiusRst;
      tube_radius_q <= ccpp_pkg::TubeRadiusRst;
      end_x_q       <= ccpp_pkg::EndXRst;
      end_y_q       <= ccpp_pkg::EndYRst;
      center_y_q    <= ccpp_pkg::CenterYRst;
    end else if (cfg_we_i) begin
      unique case (ccpp_pkg::cfg_idx_e'(cfg_addr_i))
        ccpp_pkg::CFG_ARC_RADIUS:  arc_radius_q  <= cfg_wdata_i[30:0];
        ccpp_pkg::CFG_TUBE_RADIUS: tube_radius_q <= cfg_wdata_i[30:0];
        ccpp_pkg::CFG_END_X:       end_x_q       <= cfg_wdata_i[30:0];
        ccpp_pkg::CFG_END_Y:       end_y_q       <= cfg_wdata_i[30:0];
        ccpp_pkg::CFG_CENTER_Y:    center_y_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  ccpp_pkg::out_beat_t out_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Stage A: offset from the arc center.
  logic        a_vld_q;
  logic [31:0] a_px_q, a_py_q, a_pz_q;
  logic [32:0] a_cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_px_q <= in_data_i.pos_x;
      a_py_q <= in_data_i.pos_y;
      a_pz_q <= (DIMENSIONS > 2) ? in_data_i.pos_z : 32'd0;
      a_cy_q <= {in_data_i.pos_y[31], in_data_i.pos_y} - {center_y_q[31], center_y_q};
    end
  end

  // Stage B: magnitudes and squares.
  logic        b_vld_q;
  logic [31:0] b_px_q, b_py_q, b_pz_q;
  logic        b_neg_x_q, b_neg_y_q;
  logic [32:0] b_mag_x_q, b_mag_y_q;
  logic [65:0] b_sq_x_q, b_sq_y_q;
  logic [32:0] b_mag_x_d, b_mag_y_d;

  always_comb begin
    b_mag_x_d = a_px_q[31] ? (33'd0 - {a_px_q[31], a_px_q}) : {1'b0, a_px_q};
    b_mag_y_d = a_cy_q[32] ? (33'd0 - a_cy_q) : a_cy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_px_q    <= a_px_q;
      b_py_q    <= a_py_q;
      b_pz_q    <= a_pz_q;
      b_neg_x_q <= a_px_q[31];
      b_neg_y_q <= a_cy_q[32];
      b_mag_x_q <= b_mag_x_d;
      b_mag_y_q <= b_mag_y_d;
      b_sq_x_q  <= 66'(b_mag_x_d) * 66'(b_mag_x_d);
      b_sq_y_q  <= 66'(b_mag_y_d) * 66'(b_mag_y_d);
    end
  end

  // Stage C: squared xy norm.
  logic             c_vld_q;
  logic [66:0]      c_s_q;
  ccpp_pkg::ctx_a_t c_ctx_q;
  logic [66:0]      c_s_d;

  assign c_s_d = 67'(b_sq_x_q) + 67'(b_sq_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_s_q         <= c_s_d;
      c_ctx_q.pos_x <= b_px_q;
      c_ctx_q.pos_y <= b_py_q;
      c_ctx_q.pos_z <= b_pz_q;
      c_ctx_q.neg_x <= b_neg_x_q;
      c_ctx_q.neg_y <= b_neg_y_q;
      c_ctx_q.mag_x <= b_mag_x_q;
      c_ctx_q.mag_y <= b_mag_y_q;
      c_ctx_q.zero1 <= (c_s_d == 67'd0);
    end
  end

  logic             s1_vld;
  logic [RootW-1:0] s1_root;
  ccpp_pkg::ctx_a_t s1_ctx;

  ccpp_sqrt #(
    .IW  (RadW),
    .SBW ($bits(ccpp_pkg::ctx_a_t))
  ) u_sqrt1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (c_vld_q),
    .rad_i  (RadW'(c_s_q)),
    .sb_i   (c_ctx_q),
    .vld_o  (s1_vld),
    .root_o (s1_root),
    .sb_o   (s1_ctx)
  );

  // Stage D: scale offsets by the arc radius.
  logic                   d_vld_q;
  logic [1:0][NumW-1:0]   d_num_q;
  logic [RootW-1:0]       d_den_q;
  ccpp_pkg::ctx_b_t       d_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= s1_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_num_q[0]    <= NumW'(s1_ctx.mag_x) * NumW'(arc_radius_q);
      d_num_q[1]    <= NumW'(s1_ctx.mag_y) * NumW'(arc_radius_q);
      d_den_q       <= s1_root;
      d_ctx_q.pos_x <= s1_ctx.pos_x;
      d_ctx_q.pos_y <= s1_ctx.pos_y;
      d_ctx_q.pos_z <= s1_ctx.pos_z;
      d_ctx_q.neg_x <= s1_ctx.neg_x;
      d_ctx_q.neg_y <= s1_ctx.neg_y;
      d_ctx_q.zero1 <= s1_ctx.zero1;
    end
  end

  logic                 v1_vld;
  logic [1:0][QuoW-1:0] v1_quo;
  ccpp_pkg::ctx_b_t     v1_ctx;

  ccpp_div #(
    .LANES (2),
    .NW    (NumW),
    .DW    (RootW),
    .QW    (QuoW),
    .SBW   ($bits(ccpp_pkg::ctx_b_t))
  ) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld_q),
    .num_i  (d_num_q),
    .den_i  (d_den_q),
    .sb_i   (d_ctx_q),
    .vld_o  (v1_vld),
    .quo_o  (v1_quo),
    .sb_o   (v1_ctx)
  );

  // Stage E: backbone point on the full circle.
  logic        e_vld_q;
  logic [31:0] e_bx_q, e_px_q, e_py_q, e_pz_q;
  logic [33:0] e_by_q;
  logic        e_zero1_q;
  logic [31:0] e_qx;
  logic [33:0] e_qy;

  assign e_qx = {1'b0, v1_quo[0]};
  assign e_qy = {3'b000, v1_quo[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (en) e_vld_q <= v1_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_bx_q    <= v1_ctx.neg_x ? (32'd0 - e_qx) : e_qx;
      e_by_q    <= {{2{center_y_q[31]}}, center_y_q} +
                   (v1_ctx.neg_y ? (34'd0 - e_qy) : e_qy);
      e_px_q    <= v1_ctx.pos_x;
      e_py_q    <= v1_ctx.pos_y;
      e_pz_q    <= v1_ctx.pos_z;
      e_zero1_q <= v1_ctx.zero1;
    end
  end

  // Stage F: clamp to the arc end and take the difference vector.
  logic        f_vld_q;
  logic [31:0] f_bx_q, f_dz_q;
  logic [33:0] f_by_q;
  logic [32:0] f_dx_q;
  logic [34:0] f_dy_q;
  logic        f_zero1_q;
  logic [31:0] f_bx_d;
  logic [33:0] f_by_d;

  always_comb begin
    if ($signed(e_by_q) > $signed({3'b000, end_y_q})) begin
      f_bx_d = e_px_q[31] ? (32'd0 - {1'b0, end_x_q}) : {1'b0, end_x_q};
      f_by_d = {3'b000, end_y_q};
    end else begin
      f_bx_d = e_bx_q;
      f_by_d = e_by_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else if (en) f_vld_q <= e_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_bx_q    <= f_bx_d;
      f_by_q    <= f_by_d;
      f_dx_q    <= {e_px_q[31], e_px_q} - {f_bx_d[31], f_bx_d};
      f_dy_q    <= {{3{e_py_q[31]}}, e_py_q} - {f_by_d[33], f_by_d};
      f_dz_q    <= e_pz_q;
      f_zero1_q <= e_zero1_q;
    end
  end

  // Stage G: magnitudes and squares of the difference, tube radius squared.
  logic             g_vld_q;
  ccpp_pkg::ctx_c_t g_ctx_q;
  logic [65:0]      g_sq_x_q, g_sq_y_q;
  logic [63:0]      g_sq_z_q;
  logic [61:0]      g_lim_q;
  logic [32:0]      g_mag_x_d, g_mag_y_d;
  logic [31:0]      g_mag_z_d;
  logic [34:0]      g_abs_y;

  always_comb begin
    g_mag_x_d = f_dx_q[32] ? (33'd0 - f_dx_q) : f_dx_q;
    g_abs_y   = f_dy_q[34] ? (35'd0 - f_dy_q) : f_dy_q;
    g_mag_y_d = g_abs_y[32:0];
    g_mag_z_d = f_dz_q[31] ? (32'd0 - f_dz_q) : f_dz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_vld_q <= 1'b0;
    else if (en) g_vld_q <= f_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_ctx_q.bx        <= f_bx_q;
      g_ctx_q.by        <= f_by_q;
      g_ctx_q.neg_x     <= f_dx_q[32];
      g_ctx_q.neg_y     <= f_dy_q[34];
      g_ctx_q.neg_z     <= f_dz_q[31];
      g_ctx_q.mag_x     <= g_mag_x_d;
      g_ctx_q.mag_y     <= g_mag_y_d;
      g_ctx_q.mag_z     <= g_mag_z_d;
      g_ctx_q.is_inside <= 1'b0;
      g_ctx_q.zero1     <= f_zero1_q;
      g_ctx_q.zero2     <= 1'b0;
      g_sq_x_q          <= 66'(g_mag_x_d) * 66'(g_mag_x_d);
      g_sq_y_q          <= 66'(g_mag_y_d) * 66'(g_mag_y_d);
      g_sq_z_q          <= 64'(g_mag_z_d) * 64'(g_mag_z_d);
      g_lim_q           <= 62'(tube_radius_q) * 62'(tube_radius_q);
    end
  end

  // Stage H: squared distance and the inside test.
  logic             h_vld_q;
  logic [RadW-1:0]  h_s_q;
  ccpp_pkg::ctx_c_t h_ctx_q;
  logic [RadW-1:0]  h_s_d;
  ccpp_pkg::ctx_c_t h_ctx_d;

  assign h_s_d = RadW'(g_sq_x_q) + RadW'(g_sq_y_q) + RadW'(g_sq_z_q);

  always_comb begin
    h_ctx_d           = g_ctx_q;
    h_ctx_d.is_inside = (h_s_d <= RadW'(g_lim_q));
    h_ctx_d.zero2     = (h_s_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_vld_q <= 1'b0;
    else if (en) h_vld_q <= g_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_s_q   <= h_s_d;
      h_ctx_q <= h_ctx_d;
    end
  end

  logic             s2_vld;
  logic [RootW-1:0] s2_root;
  ccpp_pkg::ctx_c_t s2_ctx;

  ccpp_sqrt #(
    .IW  (RadW),
    .SBW ($bits(ccpp_pkg::ctx_c_t))
  ) u_sqrt2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (h_vld_q),
    .rad_i  (h_s_q),
    .sb_i   (h_ctx_q),
    .vld_o  (s2_vld),
    .root_o (s2_root),
    .sb_o   (s2_ctx)
  );

  // Stage I: scale the difference by the tube radius.
  logic                          i_vld_q;
  logic [DIMENSIONS-1:0][NumW-1:0] i_num_q;
  logic [DIMENSIONS-1:0][NumW-1:0] i_num_d;
  logic [RootW-1:0]              i_den_q;
  ccpp_pkg::ctx_d_t              i_ctx_q;

  always_comb begin
    i_num_d[0] = NumW'(s2_ctx.mag_x) * NumW'(tube_radius_q);
    i_num_d[1] = NumW'(s2_ctx.mag_y) * NumW'(tube_radius_q);
    if (DIMENSIONS > 2) begin
      i_num_d[DIMENSIONS-1] = NumW'(s2_ctx.mag_z) * NumW'(tube_radius_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_vld_q <= 1'b0;
    else if (en) i_vld_q <= s2_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_num_q           <= i_num_d;
      i_den_q           <= s2_root;
      i_ctx_q.bx        <= s2_ctx.bx;
      i_ctx_q.by        <= s2_ctx.by;
      i_ctx_q.neg_x     <= s2_ctx.neg_x;
      i_ctx_q.neg_y     <= s2_ctx.neg_y;
      i_ctx_q.neg_z     <= s2_ctx.neg_z;
      i_ctx_q.is_inside <= s2_ctx.is_inside;
      i_ctx_q.zero1     <= s2_ctx.zero1;
      i_ctx_q.zero2     <= s2_ctx.zero2;
    end
  end

  logic                          v2_vld;
  logic [DIMENSIONS-1:0][QuoW-1:0] v2_quo;
  ccpp_pkg::ctx_d_t              v2_ctx;

  ccpp_div #(
    .LANES (DIMENSIONS),
    .NW    (NumW),
    .DW    (RootW),
    .QW    (QuoW),
    .SBW   ($bits(ccpp_pkg::ctx_d_t))
  ) u_div2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (i_vld_q),
    .num_i  (i_num_q),
    .den_i  (i_den_q),
    .sb_i   (i_ctx_q),
    .vld_o  (v2_vld),
    .quo_o  (v2_quo),
    .sb_o   (v2_ctx)
  );

  // Stage J: surface point, saturation and the special cases.
  logic [35:0] j_qx, j_qy, j_qz, j_sx, j_sy, j_sz;
  ccpp_pkg::out_beat_t out_d;

  always_comb begin
    j_qx = {5'd0, v2_quo[0]};
    j_qy = {5'd0, v2_quo[1]};
    j_qz = (DIMENSIONS > 2) ? {5'd0, v2_quo[DIMENSIONS-1]} : 36'd0;
    j_sx = v2_ctx.neg_x ? (36'd0 - j_qx) : j_qx;
    j_sy = v2_ctx.neg_y ? (36'd0 - j_qy) : j_qy;
    j_sz = v2_ctx.neg_z ? (36'd0 - j_qz) : j_qz;
    out_d.is_inside  = v2_ctx.is_inside;
    out_d.degenerate = v2_ctx.zero1 || v2_ctx.zero2;
    out_d.proj_x     = ccpp_pkg::sat32({{4{v2_ctx.bx[31]}}, v2_ctx.bx} + j_sx);
    out_d.proj_y     = ccpp_pkg::sat32({{2{v2_ctx.by[33]}}, v2_ctx.by} + j_sy);
    out_d.proj_z     = ccpp_pkg::sat32(j_sz);
    if (v2_ctx.zero1 || v2_ctx.zero2) begin
      out_d.proj_x = '0;
      out_d.proj_y = '0;
      out_d.proj_z = '0;
    end
    // At the arc center nothing downstream means anything.
    if (v2_ctx.zero1) begin
      out_d.is_inside = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= v2_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `CCPP_ASSERT_IMPLIES(a_degen_zero, out_valid_o && out_data_o.degenerate, out_data_o.proj_x == 32'sd0 && out_data_o.proj_y == 32'sd0 && out_data_o.proj_z == 32'sd0, "degenerate beat carries a nonzero projection")
  `CCPP_ASSERT_NEXT(a_stall_freeze, !in_ready_o, $stable(h_vld_q) && $stable(s2_vld), "pipeline moved during a stall")
  `CCPP_ASSERT_IMPLIES(a_planar_z, out_valid_o && (DIMENSIONS < 3), out_data_o.proj_z == 32'sd0, "planar mode produced a z component")

endmodule

`default_nettype wire

@@ src/ccpp_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband.
// Standalone; uses no package.
`default_nettype none

module ccpp_sqrt #(
  parameter int unsigned IW  = 68,
  parameter int unsigned SBW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [IW-1:0]     rad_i,
  input  logic [SBW-1:0]    sb_i,
  output logic              vld_o,
  output logic [IW/2-1:0]   root_o,
  output logic [SBW-1:0]    sb_o
);

  localparam int unsigned RW = IW / 2;

  logic [RW-1:0]  vld_q, vld_d;
  logic [IW-1:0]  rad_q  [RW];
  logic [IW-1:0]  rad_d  [RW];
  logic [RW:0]    rem_q  [RW];
  logic [RW:0]    rem_d  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [RW-1:0]  root_d [RW];
  logic [SBW-1:0] sb_q   [RW];
  logic [SBW-1:0] sb_d   [RW];

  // One restoring step: bring down two radicand bits, try root*4+1.
  function automatic void sqrt_step(
    input  logic [IW-1:0] rad,
    input  logic [RW:0]   rem,
    input  logic [RW-1:0] root,
    output logic [IW-1:0] rad_n,
    output logic [RW:0]   rem_n,
    output logic [RW-1:0] root_n
  );
    logic [RW+2:0] part;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;
    part   = {rem, rad[IW-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = part - trial;
    ge     = (part >= trial);
    rem_n  = ge ? diff[RW:0] : part[RW:0];
    root_n = {root[RW-2:0], ge};
    rad_n  = rad << 2;
  endfunction

  always_comb begin
    vld_d[0] = vld_i;
    sb_d[0]  = sb_i;
    sqrt_step(rad_i, '0, '0, rad_d[0], rem_d[0], root_d[0]);
    for (int k = 1; k < RW; k++) begin
      vld_d[k] = vld_q[k-1];
      sb_d[k]  = sb_q[k-1];
      sqrt_step(rad_q[k-1], rem_q[k-1], root_q[k-1], rad_d[k], rem_d[k], root_d[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      sb_q   <= sb_d;
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign sb_o   = sb_q[RW-1];

endmodule

`default_nettype wire

@@ src/ccpp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with sideband. Standalone; uses no package.
`default_nettype none

module ccpp_div #(
  parameter int unsigned LANES = 2,
  parameter int unsigned NW    = 64,
  parameter int unsigned DW    = 34,
  parameter int unsigned QW    = 31,
  parameter int unsigned SBW   = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SBW-1:0]             sb_i,
  output logic                       vld_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SBW-1:0]             sb_o
);

  // The quotient is known to fit QW bits, so num >> QW is below the divisor.
  logic [QW-1:0]                 vld_q, vld_d;
  logic [LANES-1:0][DW-1:0]      rem_q [QW];
  logic [LANES-1:0][DW-1:0]      rem_d [QW];
  logic [LANES-1:0][QW-1:0]      lo_q  [QW];
  logic [LANES-1:0][QW-1:0]      lo_d  [QW];
  logic [LANES-1:0][QW-1:0]      quo_q [QW];
  logic [LANES-1:0][QW-1:0]      quo_d [QW];
  logic [DW-1:0]                 den_q [QW];
  logic [DW-1:0]                 den_d [QW];
  logic [SBW-1:0]                sb_q  [QW];
  logic [SBW-1:0]                sb_d  [QW];

  function automatic void div_step(
    input  logic [DW-1:0] rem,
    input  logic [QW-1:0] lo,
    input  logic [QW-1:0] quo,
    input  logic [DW-1:0] den,
    output logic [DW-1:0] rem_n,
    output logic [QW-1:0] lo_n,
    output logic [QW-1:0] quo_n
  );
    logic [DW:0] part;
    logic [DW:0] diff;
    logic        ge;
    part  = {rem, lo[QW-1]};
    diff  = part - {1'b0, den};
    ge    = (part >= {1'b0, den});
    rem_n = ge ? diff[DW-1:0] : part[DW-1:0];
    lo_n  = lo << 1;
    quo_n = {quo[QW-2:0], ge};
  endfunction

  always_comb begin
    vld_d[0] = vld_i;
    sb_d[0]  = sb_i;
    den_d[0] = den_i;
    for (int l = 0; l < LANES; l++) begin
      div_step(DW'(num_i[l][NW-1:QW]), num_i[l][QW-1:0], '0, den_i,
               rem_d[0][l], lo_d[0][l], quo_d[0][l]);
    end
    for (int k = 1; k < QW; k++) begin
      vld_d[k] = vld_q[k-1];
      sb_d[k]  = sb_q[k-1];
      den_d[k] = den_q[k-1];
      for (int l = 0; l < LANES; l++) begin
        div_step(rem_q[k-1][l], lo_q[k-1][l], quo_q[k-1][l], den_q[k-1],
                 rem_d[k][l], lo_d[k][l], quo_d[k][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
      quo_q <= quo_d;
      den_q <= den_d;
      sb_q  <= sb_d;
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

`default_nettype wire
